@@ src/swtb_pkg.sv @@
// Package for the software timer bank core: opcodes, sizing defaults and the result record.
// Has no dependencies. The top level imports it.
package swtb_pkg;

    localparam int DEF_NUM_TIMERS  = 16;
    localparam int DEF_COUNT_WIDTH = 32;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 72;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [6:0] PRESCALE_LAST = 7'd99;
    localparam logic [4:0] MAX_RESULTS   = 5'd16;

    typedef struct packed {
        logic        ev;
        logic [3:0]  idx;
        logic        last;
        logic        strobe;
        logic [31:0] millis;
        logic        run;
        logic        exp;
        logic [31:0] rem;
    } t_result;

endpackage

@@ src/software_timer_bank_core.sv @@
// Software timer bank core: countdown timers with auto-reload, driven by a tick stream.
// A tick scans the timer memory: one slot is read, updated and written back per cycle
// while no back pressure stalls the scan, then a flush state sends the last result.
// Start, stop and read read the memory on accept, then write back and send the result.
// Synchronous active-low reset clears the timer valid bits, counters and handshake state.
// Depends on swtb_pkg.
module software_timer_bank_core #(
    parameter int NUM_TIMERS  = swtb_pkg::DEF_NUM_TIMERS,
    parameter int COUNT_WIDTH = swtb_pkg::DEF_COUNT_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // Fields from bit 0: timer_index[3:0], interval[35:4], auto_reload[36], zero fill.
    input  logic [swtb_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // Fields from bit 0: opcode[1:0].
    input  logic [1:0]                        i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // Fields from bit 0: event_index[3:0], hundred_ms_strobe[4], millis_count[36:5],
    // running_flag[37], expired_flag[38], remaining[70:39], zero fill.
    output logic [swtb_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    // Fields from bit 0: expired_event[0].
    output logic                              o_m_tuser,
    output logic                              o_m_tlast
);
    import swtb_pkg::*;

    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(NUM_TIMERS - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_TICK  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;
    localparam logic [1:0] S_OP    = 2'd3;

    typedef struct packed {
        logic                   run;
        logic                   exp;
        logic                   rl;
        logic [COUNT_WIDTH-1:0] cnt;
        logic [COUNT_WIDTH-1:0] rv;
    } t_entry;

    t_entry mem [NUM_TIMERS];

    logic [1:0]             r_state, n_state;
    logic [NUM_TIMERS-1:0]  r_valid;
    logic [31:0]            r_ticks, n_ticks;
    logic [6:0]             r_prescale, n_prescale;
    logic                   r_strobe, n_strobe;
    logic [4:0]             r_nemit, n_nemit;
    logic [AW-1:0]          r_proc_idx, n_proc_idx;
    logic                   r_out_v, n_out_v;
    logic                   r_pend_v, n_pend_v;
    t_result                r_out, n_out;
    t_result                r_pend, n_pend;
    logic [1:0]             r_opc, n_opc;
    logic [3:0]             r_idx, n_idx;
    logic [AW-1:0]          r_op_addr, n_op_addr;
    logic                   r_in_range, n_in_range;
    logic [COUNT_WIDTH-1:0] r_interval, n_interval;
    logic                   r_ar, n_ar;
    t_entry                 r_q;
    logic                   r_q_vld;

    logic          mem_we;
    logic [AW-1:0] mem_wa;
    t_entry        mem_wd;
    logic [AW-1:0] rd_addr;

    t_entry                 ent_q, ent_t, ent_o;
    logic [COUNT_WIDTH-1:0] cnt_dec;
    logic                   hit, emit, stall, out_free, in_rng_in;
    t_result                res_t, res_none, res_op;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_v;
    assign o_m_tuser  = r_out.ev;
    assign o_m_tlast  = r_out.last;
    assign o_m_tdata  = {1'b0, r_out.rem, r_out.exp, r_out.run, r_out.millis,
                         r_out.strobe, r_out.idx};

    always_comb begin
        ent_q    = r_q_vld ? r_q : '0;
        out_free = !r_out_v || i_m_tready;

        cnt_dec = (ent_q.cnt != '0) ? ent_q.cnt - 1'b1 : '0;
        hit     = ent_q.run && (cnt_dec == '0);
        ent_t   = ent_q;
        if (ent_q.run) begin
            ent_t.cnt = cnt_dec;
        end
        if (hit) begin
            ent_t.cnt = ent_q.rl ? ent_q.rv : cnt_dec;
            ent_t.run = ent_q.rl;
            ent_t.exp = 1'b1;
        end
        emit  = hit && (r_nemit != MAX_RESULTS);
        stall = emit && r_pend_v && !out_free;

        res_t        = '0;
        res_t.ev     = 1'b1;
        res_t.idx    = 4'(r_proc_idx);
        res_t.strobe = r_strobe;
        res_t.millis = r_ticks;
        res_t.run    = ent_t.run;
        res_t.exp    = ent_t.exp;
        res_t.rem    = 32'(ent_t.cnt);

        res_none        = '0;
        res_none.strobe = r_strobe;
        res_none.millis = r_ticks;

        ent_o = ent_q;
        case (r_opc)
            OP_START: begin
                ent_o.rv  = r_interval;
                ent_o.cnt = r_interval;
                ent_o.rl  = r_ar;
                ent_o.exp = 1'b0;
                ent_o.run = 1'b1;
            end
            OP_STOP: begin
                ent_o.run = 1'b0;
            end
            default: begin
                ent_o = ent_q;
            end
        endcase
        res_op        = '0;
        res_op.idx    = r_idx;
        res_op.last   = 1'b1;
        res_op.millis = r_ticks;
        if (r_in_range) begin
            res_op.run = ent_o.run;
            res_op.exp = ent_o.exp;
            res_op.rem = 32'(ent_o.cnt);
        end

        in_rng_in = (32'(i_s_tdata[3:0]) < NUM_TIMERS);

        n_state    = r_state;
        n_ticks    = r_ticks;
        n_prescale = r_prescale;
        n_strobe   = r_strobe;
        n_nemit    = r_nemit;
        n_proc_idx = r_proc_idx;
        n_out_v    = r_out_v;
        n_pend_v   = r_pend_v;
        n_out      = r_out;
        n_pend     = r_pend;
        n_opc      = r_opc;
        n_idx      = r_idx;
        n_op_addr  = r_op_addr;
        n_in_range = r_in_range;
        n_interval = r_interval;
        n_ar       = r_ar;
        mem_we     = 1'b0;
        mem_wa     = r_proc_idx;
        mem_wd     = ent_t;
        rd_addr    = r_proc_idx;

        if (r_out_v && i_m_tready) begin
            n_out_v = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                rd_addr = '0;
                if (i_s_tvalid) begin
                    n_opc      = i_s_tuser;
                    n_idx      = i_s_tdata[3:0];
                    n_interval = COUNT_WIDTH'(i_s_tdata[35:4]);
                    n_ar       = i_s_tdata[36];
                    n_in_range = in_rng_in;
                    n_op_addr  = in_rng_in ? AW'(i_s_tdata[3:0]) : '0;
                    if (i_s_tuser == OP_TICK) begin
                        n_ticks    = r_ticks + 32'd1;
                        n_strobe   = (r_prescale == PRESCALE_LAST);
                        n_prescale = (r_prescale == PRESCALE_LAST) ? '0 : r_prescale + 7'd1;
                        n_proc_idx = '0;
                        n_nemit    = '0;
                        n_state    = S_TICK;
                    end else begin
                        rd_addr = n_op_addr;
                        n_state = S_OP;
                    end
                end
            end
            S_TICK: begin
                if (!stall) begin
                    mem_we = ent_q.run;
                    if (emit) begin
                        n_nemit  = r_nemit + 5'd1;
                        n_pend   = res_t;
                        n_pend_v = 1'b1;
                        if (r_pend_v) begin
                            n_out   = r_pend;
                            n_out_v = 1'b1;
                        end
                    end
                    if (r_proc_idx == LAST_SLOT) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_proc_idx = r_proc_idx + 1'b1;
                        rd_addr    = r_proc_idx + 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_out      = r_pend_v ? r_pend : res_none;
                    n_out.last = 1'b1;
                    n_out_v    = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            S_OP: begin
                rd_addr = r_op_addr;
                mem_wa  = r_op_addr;
                mem_wd  = ent_o;
                if (out_free) begin
                    mem_we  = r_in_range && (r_opc == OP_START || r_opc == OP_STOP);
                    n_out   = res_op;
                    n_out_v = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_q <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_q_vld    <= 1'b0;
            r_ticks    <= '0;
            r_prescale <= '0;
            r_strobe   <= 1'b0;
            r_nemit    <= '0;
            r_proc_idx <= '0;
            r_out_v    <= 1'b0;
            r_pend_v   <= 1'b0;
        end else begin
            r_state    <= n_state;
            if (mem_we) begin
                r_valid[mem_wa] <= 1'b1;
            end
            r_q_vld    <= r_valid[rd_addr];
            r_ticks    <= n_ticks;
            r_prescale <= n_prescale;
            r_strobe   <= n_strobe;
            r_nemit    <= n_nemit;
            r_proc_idx <= n_proc_idx;
            r_out_v    <= n_out_v;
            r_pend_v   <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out      <= n_out;
        r_pend     <= n_pend;
        r_opc      <= n_opc;
        r_idx      <= n_idx;
        r_op_addr  <= n_op_addr;
        r_in_range <= n_in_range;
        r_interval <= n_interval;
        r_ar       <= n_ar;
    end

`ifndef SYNTHESIS
    a_pend_in_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_state == S_TICK || r_state == S_FLUSH))
        else $error("Pending result held outside a tick scan.");

    a_emit_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nemit <= MAX_RESULTS)
        else $error("Tick emitted more results than allowed.");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_TICK || r_state == S_OP))
        else $error("Timer memory written outside a tick scan or operation.");

    a_event_expired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> o_m_tdata[38])
        else $error("Expiry event without expired flag.");
`endif

endmodule

@@ bench/timer_bank_checker.sv @@
`timescale 1ns / 1ps
// Checker for the software timer bank core: watches both stream channels, keeps its own
// copy of the timer bank and compares every result against it. Depends on swtb_pkg.
module timer_bank_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic [swtb_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic [1:0]                       i_s_tuser,
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [swtb_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                             i_m_tuser,
    input  logic                             i_m_tlast,
    output int                               o_fail_count,
    output int                               o_pending
);
    import swtb_pkg::*;

    localparam int NT = DEF_NUM_TIMERS;

    logic        tmr_running [NT];
    logic        tmr_expired [NT];
    logic        tmr_auto    [NT];
    logic [31:0] tmr_count   [NT];
    logic [31:0] tmr_reload  [NT];
    logic [31:0] tick_total;
    logic [6:0]  prescale;

    t_result awaited_results[$];
    int      failures = 0;

    function automatic t_result make_result(logic ev, logic [3:0] idx, logic strobe,
                                            logic run, logic exp, logic [31:0] rem);
        t_result r;
        r.ev     = ev;
        r.idx    = idx;
        r.last   = 1'b0;
        r.strobe = strobe;
        r.millis = tick_total;
        r.run    = run;
        r.exp    = exp;
        r.rem    = rem;
        return r;
    endfunction

    function automatic string describe(t_result r);
        return $sformatf("ev=%0b idx=%0d last=%0b strobe=%0b millis=%0d run=%0b exp=%0b rem=%h",
                         r.ev, r.idx, r.last, r.strobe, r.millis, r.run, r.exp, r.rem);
    endfunction

    task automatic clear_timer_state();
        for (int i = 0; i < NT; i++) begin
            tmr_running[i] = 1'b0;
            tmr_expired[i] = 1'b0;
            tmr_auto[i]    = 1'b0;
            tmr_count[i]   = '0;
            tmr_reload[i]  = '0;
        end
        tick_total = '0;
        prescale   = '0;
    endtask

    // A tick yields one result per expiring timer in index order, or one idle result.
    task automatic advance_timers_on_tick();
        t_result held;
        logic    have_held;
        logic    strobe;
        have_held  = 1'b0;
        strobe     = 1'b0;
        tick_total = tick_total + 32'd1;
        prescale   = prescale + 7'd1;
        if (prescale > PRESCALE_LAST) begin
            strobe   = 1'b1;
            prescale = '0;
        end
        for (int i = 0; i < NT; i++) begin
            if (tmr_running[i]) begin
                if (tmr_count[i] != 0)
                    tmr_count[i] = tmr_count[i] - 32'd1;
                if (tmr_count[i] == 0) begin
                    if (tmr_auto[i])
                        tmr_count[i] = tmr_reload[i];
                    else
                        tmr_running[i] = 1'b0;
                    tmr_expired[i] = 1'b1;
                    if (have_held)
                        awaited_results.push_back(held);
                    held = make_result(1'b1, i[3:0], strobe, tmr_running[i],
                                       tmr_expired[i], tmr_count[i]);
                    have_held = 1'b1;
                end
            end
        end
        if (!have_held)
            held = make_result(1'b0, 4'd0, strobe, 1'b0, 1'b0, 32'd0);
        held.last = 1'b1;
        awaited_results.push_back(held);
    endtask

    task automatic apply_timer_command(logic [1:0] op, logic [3:0] idx,
                                       logic [31:0] interval, logic auto_reload);
        t_result r;
        if (op == OP_START) begin
            tmr_reload[idx]  = interval;
            tmr_count[idx]   = interval;
            tmr_auto[idx]    = auto_reload;
            tmr_expired[idx] = 1'b0;
            tmr_running[idx] = 1'b1;
        end else if (op == OP_STOP) begin
            tmr_running[idx] = 1'b0;
        end
        r = make_result(1'b0, idx, 1'b0, tmr_running[idx], tmr_expired[idx], tmr_count[idx]);
        r.last = 1'b1;
        awaited_results.push_back(r);
    endtask

    task automatic check_result();
        t_result got;
        t_result want;
        got.ev     = i_m_tuser;
        got.idx    = i_m_tdata[3:0];
        got.last   = i_m_tlast;
        got.strobe = i_m_tdata[4];
        got.millis = i_m_tdata[36:5];
        got.run    = i_m_tdata[37];
        got.exp    = i_m_tdata[38];
        got.rem    = i_m_tdata[70:39];
        if (awaited_results.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("unexpected result: %s", describe(got));
        end else begin
            want = awaited_results.pop_front();
            if (got !== want) begin
                failures++;
                if (failures <= 10)
                    $display("result mismatch\n  expected %s\n  actual   %s",
                             describe(want), describe(got));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_timer_state();
            awaited_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready)
                check_result();
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == OP_TICK)
                    advance_timers_on_tick();
                else
                    apply_timer_command(i_s_tuser, i_s_tdata[3:0], i_s_tdata[35:4],
                                        i_s_tdata[36]);
            end
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= failures;
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the timer bank testbench: clock, reset, directed and random stimulus, receiver
// back pressure and the verdict. Depends on swtb_pkg, timer_bank_checker and the core.
module tb_top;
    import swtb_pkg::*;

    localparam int ITEM_TARGET = 420;
    localparam int STALL_LIMIT = 5000;

    logic                   clk;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [1:0]             s_tuser  = OP_TICK;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;

    int fail_count;
    int pending;
    int items_sent = 0;
    int hold_left  = 0;
    int rx_gap     = 0;
    int stall_run  = 0;
    bit idle_on    = 1'b1;
    bit hold_req   = 1'b0;

    software_timer_bank_core DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    timer_bank_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(negedge clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready = 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_tready = 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rx_gap   = $urandom_range(0, 5);
            m_tready = 1'b0;
        end else begin
            m_tready = 1'b1;
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_run = 0;
        else
            stall_run++;
        if (stall_run >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_op(logic [1:0] op, logic [3:0] idx, logic [31:0] interval,
                           logic auto_reload);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {3'b000, auto_reload, interval, idx};
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // Start every timer with a very short interval so that a tick reports all of them.
    task automatic fill_bank();
        for (int i = 0; i < DEF_NUM_TIMERS; i++)
            send_op(OP_START, i[3:0], $urandom_range(0, 1), $urandom_range(0, 4) != 0);
        repeat ($urandom_range(2, 4)) send_op(OP_TICK, 4'd0, 32'd0, 1'b0);
    endtask

    initial begin
        int          pick;
        logic [31:0] interval;
        bit          hold_done;
        bit          pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_op(OP_READ,  4'd0,  32'd0,          1'b0);
        send_op(OP_START, 4'd0,  32'd0,          1'b0);
        send_op(OP_START, 4'd15, 32'hFFFF_FFFF,  1'b1);
        send_op(OP_START, 4'd1,  32'd0,          1'b1);
        send_op(OP_START, 4'd2,  32'd1,          1'b0);
        send_op(OP_START, 4'd3,  32'd2,          1'b1);
        send_op(OP_START, 4'd4,  32'h8000_0000,  1'b0);
        send_op(OP_TICK,  4'd0,  32'd0,          1'b0);
        send_op(OP_READ,  4'd0,  32'd0,          1'b0);
        send_op(OP_READ,  4'd15, 32'd0,          1'b0);
        send_op(OP_TICK,  4'd9,  32'hFFFF_FFFF,  1'b1);
        send_op(OP_TICK,  4'd0,  32'd0,          1'b0);
        send_op(OP_STOP,  4'd1,  32'd0,          1'b0);
        send_op(OP_READ,  4'd1,  32'd0,          1'b0);
        send_op(OP_STOP,  4'd14, 32'd0,          1'b0);
        send_op(OP_READ,  4'd14, 32'd0,          1'b0);
        send_op(OP_TICK,  4'd0,  32'd0,          1'b0);
        send_op(OP_START, 4'd3,  32'd3,          1'b0);
        send_op(OP_READ,  4'd3,  32'd0,          1'b0);

        fill_bank();
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= 140 && !hold_done) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (items_sent >= 280 && !pause_done) begin
                wait_for_drain();
                pause_done = 1'b1;
            end
            if (items_sent >= 360)
                idle_on = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                fill_bank();
            end else if (pick < 48) begin
                send_op(OP_TICK, 4'($urandom_range(0, 15)), $urandom,
                        1'($urandom_range(0, 1)));
            end else if (pick < 72) begin
                case ($urandom_range(0, 9))
                    0, 1:    interval = $urandom;
                    2:       interval = 32'd1 << $urandom_range(0, 31);
                    3:       interval = $urandom_range(5, 40);
                    default: interval = $urandom_range(0, 4);
                endcase
                send_op(OP_START, 4'($urandom_range(0, 15)), interval,
                        1'($urandom_range(0, 1)));
            end else if (pick < 82) begin
                send_op(OP_STOP, 4'($urandom_range(0, 15)), $urandom,
                        1'($urandom_range(0, 1)));
            end else begin
                send_op(OP_READ, 4'($urandom_range(0, 15)), $urandom,
                        1'($urandom_range(0, 1)));
            end
        end

        wait_for_drain();
        repeat (40) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
